>>> hdl/orb_pkg.sv
package orb_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int OP_W      = 3;
  localparam int WDATA_W   = 32;
  localparam int INDEX_W   = 10;
  localparam int OFFSET_W  = 11;
  localparam int RDATA_W   = 32;
  localparam int RSIZE_W   = 11;
  localparam int CFG_AW    = 3;
  localparam int CFG_DW    = 32;

  localparam logic [RSIZE_W-1:0] RING_SIZE_RESET = 11'd1024;

  localparam logic REG_RING_SIZE = 1'b0;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_RD_IDX = 3'd2,
    OP_WR_IDX = 3'd3,
    OP_RD_OLD = 3'd4,
    OP_RD_NEW = 3'd5
  } op_t;

endpackage

>>> hdl/overwriting_ring_buffer.sv
// A result strobes on out_valid after the start transfer passes the s1, s2 and
// out registers. One item per cycle while busy is low; each item makes at most
// one single-port memory access. The receiver cannot stall; results are never
// held back. Reset: pointers clear at once, then, with busy high, a pass zeroes
// the slot memory, one slot per cycle. Register writes are taken meanwhile.
module overwriting_ring_buffer #(
  parameter int DEPTH      = orb_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = orb_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [orb_pkg::OP_W-1:0]      in_op,
  input  logic [orb_pkg::WDATA_W-1:0]   in_write_data,
  input  logic [orb_pkg::INDEX_W-1:0]   in_slot_index,
  input  logic [orb_pkg::OFFSET_W-1:0]  in_age_offset,
  output logic                          out_valid,
  output logic [orb_pkg::RDATA_W-1:0]   out_read_data,
  output logic                          out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [orb_pkg::CFG_AW-1:0]    paddr,
  input  logic [orb_pkg::CFG_DW-1:0]    pwdata,
  output logic [orb_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);
  import orb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > RSIZE_W) ? SW : RSIZE_W;
  localparam int XW = CW + 1;
  localparam int SIZE_RESET_I =
    (int'(RING_SIZE_RESET) > DEPTH) ? DEPTH : int'(RING_SIZE_RESET);
  localparam logic [SW-1:0] SIZE_RESET = SW'(SIZE_RESET_I);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [RSIZE_W-1:0]    ring_size_r;
  logic [SW-1:0]         size_r, size_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic                  clr_active_r;
  logic [AW-1:0]         clr_addr_r;

  logic                  s1_valid_r, s1_we_r, s1_re_r, s1_status_r;
  logic [AW-1:0]         s1_addr_r;
  logic [DATA_WIDTH-1:0] s1_wdata_r;
  logic                  s2_valid_r, s2_rd_r, s2_status_r;
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic                  out_valid_r, out_status_r;
  logic [RDATA_W-1:0]    out_read_data_r;

  logic                  accept, cfg_wr;
  op_t                   op;
  logic [XW-1:0]         size_x, head_x, tail_x, idx_x, mag_x, depth_x, rs_x;
  logic [XW-1:0]         old_sum, new_sum, old_idx, new_idx, head_inc, tail_inc;
  logic [OFFSET_W-1:0]   mag;
  logic                  neg, want_old;
  logic                  c_we, c_re, c_status;
  logic [XW-1:0]         c_addr;
  logic [63:0]           wdata_ext, rdata_ext;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite;
  assign op     = op_t'(in_op);

  assign size_x   = XW'(size_r);
  assign head_x   = XW'(head_r);
  assign tail_x   = XW'(tail_r);
  assign idx_x    = XW'(in_slot_index);
  assign depth_x  = XW'(DEPTH);
  assign rs_x     = XW'(pwdata[RSIZE_W-1:0]);

  assign neg      = in_age_offset[OFFSET_W-1];
  assign mag      = neg ? (~in_age_offset + OFFSET_W'(1)) : in_age_offset;
  assign mag_x    = XW'(mag);
  assign want_old = (op == OP_RD_OLD) != neg;

  assign old_sum  = head_x + mag_x;
  assign new_sum  = head_x + size_x - XW'(1) - mag_x;
  assign old_idx  = (old_sum >= size_x) ? old_sum - size_x : old_sum;
  assign new_idx  = (new_sum >= size_x) ? new_sum - size_x : new_sum;
  assign head_inc = head_x + XW'(1);
  assign tail_inc = tail_x + XW'(1);

  assign wdata_ext = {32'd0, in_write_data};

  always_comb begin
    c_we     = 1'b0;
    c_re     = 1'b0;
    c_status = STATUS_OK;
    c_addr   = '0;
    head_nxt = head_r;
    tail_nxt = tail_r;
    case (op)
      OP_PUSH: begin
        c_we     = 1'b1;
        c_addr   = head_x;
        head_nxt = (head_inc < size_x) ? head_inc[AW-1:0] : '0;
      end
      OP_POP: begin
        c_re     = 1'b1;
        c_addr   = tail_x;
        tail_nxt = (tail_inc < size_x) ? tail_inc[AW-1:0] : '0;
      end
      OP_RD_IDX, OP_WR_IDX: begin
        c_addr = idx_x;
        if (idx_x >= size_x) begin
          c_status = STATUS_ERR;
        end else if (op == OP_WR_IDX) begin
          c_we = 1'b1;
        end else begin
          c_re = 1'b1;
        end
      end
      OP_RD_OLD, OP_RD_NEW: begin
        c_addr = want_old ? old_idx : new_idx;
        if (mag_x >= size_x) begin
          c_status = STATUS_ERR;
        end else begin
          c_re = 1'b1;
        end
      end
      default: c_status = STATUS_ERR;
    endcase
  end

  always_comb begin
    if (rs_x == '0) begin
      size_nxt = SW'(1);
    end else if (rs_x > depth_x) begin
      size_nxt = SW'(DEPTH);
    end else begin
      size_nxt = rs_x[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_size_r  <= RING_SIZE_RESET;
      size_r       <= SIZE_RESET;
      head_r       <= '0;
      tail_r       <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(DEPTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (cfg_wr && paddr[2] == REG_RING_SIZE) begin
        ring_size_r <= pwdata[RSIZE_W-1:0];
        size_r      <= size_nxt;
        head_r      <= '0;
        tail_r      <= '0;
      end else if (accept) begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
      end
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_we_r     <= c_we;
    s1_re_r     <= c_re;
    s1_status_r <= c_status;
    s1_addr_r   <= c_addr[AW-1:0];
    s1_wdata_r  <= wdata_ext[DATA_WIDTH-1:0];
    s2_rd_r     <= s1_re_r;
    s2_status_r <= s1_status_r;
    out_status_r    <= s2_status_r;
    out_read_data_r <= s2_rd_r ? rdata_ext[RDATA_W-1:0] : '0;
  end

  assign mem_we    = clr_active_r || (s1_valid_r && s1_we_r);
  assign mem_re    = s1_valid_r && s1_re_r;
  assign mem_addr  = clr_active_r ? clr_addr_r : s1_addr_r;
  assign mem_wdata = clr_active_r ? '0 : s1_wdata_r;
  assign rdata_ext = 64'(mem_q_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_addr];
    end
  end

  assign busy          = clr_active_r;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_RING_SIZE) ? CFG_DW'(ring_size_r) : '0;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_valid)
    else $error("result strobe missing after transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 3))
    else $error("result strobe without transfer");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STATUS_ERR) |-> out_read_data == '0)
    else $error("error result carries data");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (head_x < size_x) && (tail_x < size_x))
    else $error("pointer beyond ring size");

endmodule
